// ===== hw/rtl/fdsf_pkg.sv =====
package fdsf_pkg;

  // force word format, signed with 8 fraction bits
  localparam int unsigned FORCE_WIDTH = 24;
  localparam int unsigned AXES        = 3;

  // configuration field widths
  localparam int unsigned THRESH_W   = 23;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned CFG_DATA_W = (THRESH_W > GAIN_W) ? THRESH_W : GAIN_W;
  localparam int unsigned CFG_IDX_W  = 3;

  // datapath widths
  localparam int unsigned MAG_W   = (FORCE_WIDTH > THRESH_W) ? FORCE_WIDTH : THRESH_W;
  localparam int unsigned XO_W    = MAG_W + 1;
  localparam int unsigned D_W     = XO_W + 1;
  localparam int unsigned Q_FRAC  = 16;
  localparam int unsigned PROD_W  = D_W + GAIN_W + 1;
  localparam int unsigned TERM_W  = PROD_W - Q_FRAC;
  localparam int unsigned SUM_W   = TERM_W + 1;

  typedef logic signed [FORCE_WIDTH-1:0] force_t;
  typedef logic [THRESH_W-1:0]           thresh_t;
  typedef logic [GAIN_W-1:0]             gain_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

  localparam force_t FORCE_MAX = {1'b0, {(FORCE_WIDTH-1){1'b1}}};
  localparam force_t FORCE_MIN = {1'b1, {(FORCE_WIDTH-1){1'b0}}};

  // unity gain in Q1.16 and the rounding half
  localparam gain_t GAIN_ONE = gain_t'(1 << Q_FRAC);
  localparam int    ROUND_HALF = 1 << (Q_FRAC - 1);

  // register indexes
  localparam cfg_idx_t REG_LOWER_THRESHOLD = cfg_idx_t'(0);
  localparam cfg_idx_t REG_UPPER_THRESHOLD = cfg_idx_t'(1);
  localparam cfg_idx_t REG_OFFSET_FIRST    = cfg_idx_t'(2);
  localparam cfg_idx_t REG_OFFSET_SECOND   = cfg_idx_t'(3);
  localparam cfg_idx_t REG_OFFSET_THIRD    = cfg_idx_t'(4);
  localparam cfg_idx_t REG_SMOOTHING_GAIN  = cfg_idx_t'(5);

  // register reset values
  localparam thresh_t LOWER_THRESHOLD_RST = thresh_t'(1280);
  localparam thresh_t UPPER_THRESHOLD_RST = thresh_t'(51200);
  localparam thresh_t OFFSET_FIRST_RST    = thresh_t'(0);
  localparam thresh_t OFFSET_SECOND_RST   = thresh_t'(0);
  localparam thresh_t OFFSET_THIRD_RST    = thresh_t'(2560);
  localparam gain_t   SMOOTHING_GAIN_RST  = gain_t'(13107);

endpackage

// ===== hw/rtl/force_deadband_smoothing_filter_unit.sv =====
// Three-axis force deadband and smoothing filter. Each input word carries one
// signed force sample per axis (8 fraction bits); each axis whose magnitude lies
// within [lower_threshold, upper_threshold] has its offset pulled toward zero and
// is blended into that axis's running average as prev + gain*(x - prev), with
// round-half-up on the Q1.16 gain product and saturation to the force range; an axis
// outside the band outputs zero and keeps its average. Throughput is one word
// per clock while the output is not stalled: the band test and offset are
// registered into stage one, then the per-axis multiply and average update load
// the result register, and the updated average feeds back to the next word.
// Configuration registers (index 0 lower_threshold, 1 upper_threshold, 2..4
// per-axis offsets, 5 smoothing_gain) are written through the cfg channel,
// always ready, and must only be written while the filter is idle; indexes 6
// and 7 are ignored. A gain above 1.0 acts as 1.0.
module force_deadband_smoothing_filter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fdsf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fdsf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // force sample input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  fdsf_pkg::force_t                force_first_i,
  input  fdsf_pkg::force_t                force_second_i,
  input  fdsf_pkg::force_t                force_third_i,
  // filtered output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fdsf_pkg::force_t                filtered_first_o,
  output fdsf_pkg::force_t                filtered_second_o,
  output fdsf_pkg::force_t                filtered_third_o
);
  import fdsf_pkg::*;

  // configuration registers
  thresh_t lower_thr_q;
  thresh_t upper_thr_q;
  thresh_t offset_q [AXES];
  gain_t   gain_q;

  // pipeline control
  logic s1_valid_q;
  logic out_valid_q;
  logic out_load;
  logic s1_move;
  logic in_fire;

  // per-axis datapath
  force_t                  x_in     [AXES];
  logic                    band_d   [AXES];
  logic signed [XO_W-1:0]  xo_d     [AXES];
  logic                    s1_band_q [AXES];
  logic signed [XO_W-1:0]  s1_xo_q  [AXES];
  force_t                  sat_d    [AXES];
  force_t                  state_q  [AXES];
  force_t                  y_q      [AXES];

  gain_t                   gain_c;
  logic signed [GAIN_W:0]  gain_s;

  assign cfg_ready_o = 1'b1;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_thr_q <= LOWER_THRESHOLD_RST;
      upper_thr_q <= UPPER_THRESHOLD_RST;
      offset_q[0] <= OFFSET_FIRST_RST;
      offset_q[1] <= OFFSET_SECOND_RST;
      offset_q[2] <= OFFSET_THIRD_RST;
      gain_q      <= SMOOTHING_GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_LOWER_THRESHOLD: lower_thr_q <= cfg_data_i[THRESH_W-1:0];
        REG_UPPER_THRESHOLD: upper_thr_q <= cfg_data_i[THRESH_W-1:0];
        REG_OFFSET_FIRST:    offset_q[0] <= cfg_data_i[THRESH_W-1:0];
        REG_OFFSET_SECOND:   offset_q[1] <= cfg_data_i[THRESH_W-1:0];
        REG_OFFSET_THIRD:    offset_q[2] <= cfg_data_i[THRESH_W-1:0];
        REG_SMOOTHING_GAIN:  gain_q      <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: stage one drains into the output register when it is free
  assign out_load   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_load;
  assign in_ready_o = !s1_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign x_in[0] = force_first_i;
  assign x_in[1] = force_second_i;
  assign x_in[2] = force_third_i;

  // gain clamped to unity, as a signed multiplier operand
  assign gain_c = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;
  assign gain_s = $signed({1'b0, gain_c});

  for (genvar k = 0; k < AXES; k++) begin : g_axis
    logic                    neg;
    logic [FORCE_WIDTH-1:0]  mag_w;
    logic [MAG_W-1:0]        mag;
    logic signed [XO_W-1:0]  xw;
    logic signed [XO_W-1:0]  off_s;
    logic signed [D_W-1:0]   prev_ext;
    logic signed [D_W-1:0]   diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;
    logic signed [TERM_W-1:0] term;
    logic signed [SUM_W-1:0]  sum;
    logic                     ovf;

    // band test on the magnitude
    assign neg   = x_in[k][FORCE_WIDTH-1];
    assign mag_w = neg ? FORCE_WIDTH'(-x_in[k]) : FORCE_WIDTH'(x_in[k]);
    assign mag   = MAG_W'(mag_w);
    assign band_d[k] = (mag >= MAG_W'(lower_thr_q)) && (mag <= MAG_W'(upper_thr_q));

    // offset pulled toward zero; zero counts with the negatives
    assign xw    = {{(XO_W-FORCE_WIDTH){neg}}, x_in[k]};
    assign off_s = $signed(XO_W'(offset_q[k]));
    assign xo_d[k] = (!neg && (x_in[k] != '0)) ? (xw - off_s) : (xw + off_s);

    // blend: prev + round(gain * (x - prev)), floor after adding one half
    assign prev_ext = {{(D_W-FORCE_WIDTH){state_q[k][FORCE_WIDTH-1]}}, state_q[k]};
    assign diff     = {s1_xo_q[k][XO_W-1], s1_xo_q[k]} - prev_ext;
    assign prod     = PROD_W'(diff) * PROD_W'(gain_s);
    assign rnd      = prod + PROD_W'(ROUND_HALF);
    assign term     = rnd[PROD_W-1:Q_FRAC];
    assign sum      = {term[TERM_W-1], term}
                    + {{(SUM_W-FORCE_WIDTH){state_q[k][FORCE_WIDTH-1]}}, state_q[k]};

    // saturate when the upper bits are not a pure sign extension
    assign ovf      = !(&sum[SUM_W-1:FORCE_WIDTH-1]) && (|sum[SUM_W-1:FORCE_WIDTH-1]);
    assign sat_d[k] = ovf ? (sum[SUM_W-1] ? FORCE_MIN : FORCE_MAX) : sum[FORCE_WIDTH-1:0];
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int k = 0; k < AXES; k++) begin
        s1_band_q[k] <= band_d[k];
        s1_xo_q[k]   <= xo_d[k];
      end
    end
  end

  // smoothing state, updated only for in-band axes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < AXES; k++) begin
        state_q[k] <= '0;
      end
    end else if (s1_move) begin
      for (int k = 0; k < AXES; k++) begin
        if (s1_band_q[k]) begin
          state_q[k] <= sat_d[k];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      for (int k = 0; k < AXES; k++) begin
        y_q[k] <= s1_band_q[k] ? sat_d[k] : '0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign filtered_first_o  = y_q[0];
  assign filtered_second_o = y_q[1];
  assign filtered_third_o  = y_q[2];

  // out-of-band first axis gives zero and leaves its average alone
  a_out_of_band_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && !s1_band_q[0] |=> (filtered_first_o == '0) && $stable(state_q[0]))
    else $error("out-of-band axis changed state or gave nonzero word");

  // in-band third-axis result equals its stored average
  a_in_band_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && s1_band_q[2] |=> filtered_third_o == state_q[2])
    else $error("in-band result differs from stored average");

  // with the output stalled, a new word is only taken into an empty stage one
  a_stall_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && in_ready_o |-> !s1_valid_q)
    else $error("input accepted over a held stage one word");

endmodule
